FILE: design/aefp_pkg.sv
// Shared types and constants for the absolute encoder frame parser.
package aefp_pkg;

  localparam logic [7:0] FRAME_START = 8'h8D;
  localparam logic [7:0] SIGN_PLUS   = 8'h2D;
  localparam logic [7:0] SIGN_MINUS  = 8'h2B;
  localparam logic [7:0] VALID_MARK  = 8'hAC;

  localparam logic [3:0] IDX_SIGN   = 4'd2;
  localparam logic [3:0] IDX_TURN0  = 4'd4;
  localparam logic [3:0] IDX_TURN1  = 4'd5;
  localparam logic [3:0] IDX_TURN2  = 4'd6;
  localparam logic [3:0] IDX_TURN3  = 4'd7;
  localparam logic [3:0] IDX_MARK   = 4'd8;
  localparam logic [3:0] IDX_ANGLE0 = 4'd9;
  localparam logic [3:0] IDX_ANGLE1 = 4'd10;
  localparam logic [3:0] IDX_ANGLE2 = 4'd11;
  localparam logic [3:0] IDX_LAST   = 4'd12;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 64;
  localparam int POS_W       = 28;
  localparam int VAL_W       = 15;
  localparam int TURN_SHIFT  = 12;

  typedef struct packed {
    logic       sign_neg;
    logic [3:0] turn_d0;
    logic [3:0] turn_d1;
    logic [3:0] turn_d2;
    logic [3:0] turn_d3;
    logic [3:0] ang_d0;
    logic [3:0] ang_d1;
    logic [3:0] ang_d2;
    logic [3:0] ang_d3;
  } frame_rec_t;

  function automatic logic [VAL_W-1:0] four_digits(logic [3:0] d0, logic [3:0] d1,
                                                   logic [3:0] d2, logic [3:0] d3);
    logic [VAL_W-1:0] acc;
    acc = VAL_W'(d0) * VAL_W'(1000) + VAL_W'(d1) * VAL_W'(100)
        + VAL_W'(d2) * VAL_W'(10) + VAL_W'(d3);
    return acc;
  endfunction

endpackage

FILE: design/aefp_front.sv
// Front end: frame tracking, field capture and sign update per received byte.
module aefp_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   byte_valid,
  input  logic [7:0]             byte_data,
  output logic                   rec_push,
  output aefp_pkg::frame_rec_t   rec_data
);

  logic [3:0] byte_index_r, byte_index_nxt;
  logic       in_frame_r, in_frame_nxt;
  logic       sign_neg_r, sign_neg_nxt;
  logic [7:0] sign_byte_r;
  logic       mark_r;
  logic [3:0] turn_d0_r, turn_d1_r, turn_d2_r, turn_d3_r;
  logic [3:0] ang_d0_r, ang_d1_r, ang_d2_r;
  logic       active;
  logic       closing;

  assign active  = byte_valid && (in_frame_r || byte_data == aefp_pkg::FRAME_START);
  assign closing = active && byte_index_r == aefp_pkg::IDX_LAST;

  always_comb begin
    byte_index_nxt = byte_index_r;
    in_frame_nxt   = in_frame_r;
    sign_neg_nxt   = sign_neg_r;
    if (active) begin
      if (closing) begin
        byte_index_nxt = '0;
        in_frame_nxt   = 1'b0;
        if (sign_byte_r == aefp_pkg::SIGN_PLUS) begin
          sign_neg_nxt = 1'b0;
        end else if (sign_byte_r == aefp_pkg::SIGN_MINUS) begin
          sign_neg_nxt = 1'b1;
        end
      end else begin
        byte_index_nxt = byte_index_r + 4'd1;
        in_frame_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      in_frame_r   <= 1'b0;
      sign_neg_r   <= 1'b0;
    end else begin
      byte_index_r <= byte_index_nxt;
      in_frame_r   <= in_frame_nxt;
      sign_neg_r   <= sign_neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      case (byte_index_r)
        aefp_pkg::IDX_SIGN:   sign_byte_r <= byte_data;
        aefp_pkg::IDX_TURN0:  turn_d0_r   <= byte_data[3:0];
        aefp_pkg::IDX_TURN1:  turn_d1_r   <= byte_data[3:0];
        aefp_pkg::IDX_TURN2:  turn_d2_r   <= byte_data[3:0];
        aefp_pkg::IDX_TURN3:  turn_d3_r   <= byte_data[3:0];
        aefp_pkg::IDX_MARK:   mark_r      <= (byte_data == aefp_pkg::VALID_MARK);
        aefp_pkg::IDX_ANGLE0: ang_d0_r    <= byte_data[3:0];
        aefp_pkg::IDX_ANGLE1: ang_d1_r    <= byte_data[3:0];
        aefp_pkg::IDX_ANGLE2: ang_d2_r    <= byte_data[3:0];
        default: ;
      endcase
    end
  end

  assign rec_push = closing && mark_r;

  always_comb begin
    rec_data.sign_neg = sign_neg_nxt;
    rec_data.turn_d0  = turn_d0_r;
    rec_data.turn_d1  = turn_d1_r;
    rec_data.turn_d2  = turn_d2_r;
    rec_data.turn_d3  = turn_d3_r;
    rec_data.ang_d0   = ang_d0_r;
    rec_data.ang_d1   = ang_d1_r;
    rec_data.ang_d2   = ang_d2_r;
    rec_data.ang_d3   = byte_data[3:0];
  end

endmodule

FILE: design/aefp_fifo.sv
// Small register queue of decoded frame records between front and back end.
module aefp_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  aefp_pkg::frame_rec_t push_data,
  output logic                 full,
  output logic                 pop_valid,
  input  logic                 pop,
  output aefp_pkg::frame_rec_t pop_data
);

  aefp_pkg::frame_rec_t mem_r [aefp_pkg::FIFO_DEPTH];
  logic [aefp_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [aefp_pkg::FIFO_AW:0]   count_r, count_nxt;
  logic                         do_push, do_pop;

  assign full      = (count_r == (aefp_pkg::FIFO_AW+1)'(aefp_pkg::FIFO_DEPTH));
  assign pop_valid = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: design/aefp_back.sv
// Back end: digit weighting, signed position and output register.
module aefp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rec_valid,
  input  aefp_pkg::frame_rec_t          rec_data,
  output logic                          rec_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [aefp_pkg::POS_W-1:0]    out_position,
  output logic [aefp_pkg::VAL_W-1:0]    out_turns,
  output logic [aefp_pkg::VAL_W-1:0]    out_angle,
  output logic                          out_sign_minus
);

  logic                       s1_valid_r;
  logic [aefp_pkg::VAL_W-1:0] s1_turns_r, s1_angle_r;
  logic                       s1_sign_r;
  logic                       s1_adv, out_adv;
  logic                       out_valid_r;
  logic [aefp_pkg::POS_W-1:0] pos_r, pos_nxt, scaled;
  logic [aefp_pkg::VAL_W-1:0] turns_r, angle_r;
  logic                       sign_r;

  assign out_adv = !out_valid_r || out_ready;
  assign s1_adv  = !s1_valid_r || out_adv;
  assign rec_pop = rec_valid && s1_adv;

  always_comb begin
    scaled  = aefp_pkg::POS_W'(s1_turns_r) << aefp_pkg::TURN_SHIFT;
    pos_nxt = s1_sign_r ? ('0 - scaled - aefp_pkg::POS_W'(s1_angle_r))
                        : (scaled - aefp_pkg::POS_W'(s1_angle_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= rec_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      s1_turns_r <= aefp_pkg::four_digits(rec_data.turn_d0, rec_data.turn_d1,
                                          rec_data.turn_d2, rec_data.turn_d3);
      s1_angle_r <= aefp_pkg::four_digits(rec_data.ang_d0, rec_data.ang_d1,
                                          rec_data.ang_d2, rec_data.ang_d3);
      s1_sign_r  <= rec_data.sign_neg;
    end
    if (out_adv && s1_valid_r) begin
      pos_r   <= pos_nxt;
      turns_r <= s1_turns_r;
      angle_r <= s1_angle_r;
      sign_r  <= s1_sign_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_position   = pos_r;
  assign out_turns      = turns_r;
  assign out_angle      = angle_r;
  assign out_sign_minus = sign_r;

endmodule

FILE: design/abs_encoder_frame_parser_unit.sv
// Top level of the absolute encoder frame parser.
//
// Input stream: one received link byte per beat on in_tdata. A byte 0x8D opens
// a 13-byte frame; at the thirteenth byte the frame closes, the sign is taken
// from byte 2, and a result is queued when byte 8 is 0xAC.
// Output stream: one beat per valid frame carrying position, turns, angle and
// the sign flag.
// Throughput: one byte per cycle. in_tready drops only while the four-entry
// record queue is full, which takes a receiver stall of several frames.
// Path: after the beat of the closing byte a result passes through the queue,
// the digit weighting stage and the output register before out_tvalid rises.
// Reset (rst_n low, synchronous): no frame open, sign +1, queue and output
// empty.
// Receiver stall: out_tdata holds while out_tready is low; records build up in
// the queue and bytes keep being taken until the queue fills.
module abs_encoder_frame_parser_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [aefp_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] rx_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [aefp_pkg::OUT_TDATA_W-1:0]    out_tdata   // [27:0] position,
                                                          // [42:28] turns,
                                                          // [57:43] angle,
                                                          // [58] sign_minus,
                                                          // [63:59] zero
);

  logic                       fifo_full;
  logic                       rec_push, rec_valid, rec_pop;
  aefp_pkg::frame_rec_t       rec_in, rec_out;
  logic [aefp_pkg::POS_W-1:0] position;
  logic [aefp_pkg::VAL_W-1:0] turns, angle;
  logic                       sign_minus;

  assign in_tready = !fifo_full;

  aefp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(in_tvalid && in_tready),
    .byte_data (in_tdata),
    .rec_push  (rec_push),
    .rec_data  (rec_in)
  );

  aefp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .push_data(rec_in),
    .full     (fifo_full),
    .pop_valid(rec_valid),
    .pop      (rec_pop),
    .pop_data (rec_out)
  );

  aefp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .rec_valid     (rec_valid),
    .rec_data      (rec_out),
    .rec_pop       (rec_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_position  (position),
    .out_turns     (turns),
    .out_angle     (angle),
    .out_sign_minus(sign_minus)
  );

  assign out_tdata = {5'd0, sign_minus, angle, turns, position};

endmodule
